// File: rtl/core/gbs_pkg.sv
package gbs_pkg;

    // geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW_W      = COL_W + 1;
    localparam int IROW_W    = 17;
    localparam int OROW_W    = 16;

    // pixel layout: red in the low byte, alpha in the high byte
    localparam int CH_W  = 8;
    localparam int PIX_W = 4 * CH_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic MODE_BLUR    = 1'b0;
    localparam logic MODE_SHARPEN = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [2:0][2:0] window_t;

    // which neighbours of the centre fall outside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        logic    emit;
        logic    last;
        border_t border;
    } stage_info_t;

    // line buffer / window control
    typedef struct packed {
        logic accept;
        logic shift;
        logic clear;
    } lb_ctrl_t;

endpackage

// File: rtl/core/gbs_ram.sv
module gbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/core/gbs_window.sv
module gbs_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbs_pkg::lb_ctrl_t         ctrl,
    input  logic [gbs_pkg::COL_W-1:0] col,
    input  gbs_pkg::pixel_t           pixel,
    output gbs_pkg::window_t          win
);
    import gbs_pkg::*;

    logic [COL_W-1:0] col_reg;
    pixel_t           pix_reg;
    logic             fwd_hit_reg;
    pixel_t           fwd_up_reg;
    pixel_t           fwd_lo_reg;
    window_t          win_reg;
    window_t          win_next;

    pixel_t up_rd;
    pixel_t lo_rd;
    pixel_t up_eff;
    pixel_t lo_eff;

    // upper row line buffer
    gbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (ctrl.shift),
        .wr_addr (col_reg),
        .wr_data (lo_eff),
        .rd_en   (ctrl.accept),
        .rd_addr (col),
        .rd_data (up_rd)
    );

    // lower row line buffer
    gbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower (
        .clk     (clk),
        .wr_en   (ctrl.shift),
        .wr_addr (col_reg),
        .wr_data (pix_reg),
        .rd_en   (ctrl.accept),
        .rd_addr (col),
        .rd_data (lo_rd)
    );

    // bypass when the previous item wrote this column on the read edge
    assign up_eff = fwd_hit_reg ? fwd_up_reg : up_rd;
    assign lo_eff = fwd_hit_reg ? fwd_lo_reg : lo_rd;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            col_reg    <= col;
            pix_reg    <= pixel;
            fwd_up_reg <= lo_eff;
            fwd_lo_reg <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            fwd_hit_reg <= ctrl.shift && (col_reg == col);
        end
    end

    always_comb
    begin
        win_next = ctrl.clear ? '0 : win_reg;
        if (ctrl.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_next[r][1];
                win_next[r][1] = win_next[r][2];
            end
            win_next[0][2] = up_eff;
            win_next[1][2] = lo_eff;
            win_next[2][2] = pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

// File: rtl/core/gbs_filter.sv
module gbs_filter (
    input  gbs_pkg::window_t         win,
    input  gbs_pkg::border_t         border,
    input  logic                     mode,
    output logic [gbs_pkg::CH_W-1:0] red,
    output logic [gbs_pkg::CH_W-1:0] green,
    output logic [gbs_pkg::CH_W-1:0] blue,
    output logic [gbs_pkg::CH_W-1:0] alpha
);
    import gbs_pkg::*;

    // floor(x / 5) for x below 2048, reciprocal rounded up so exact multiples land
    localparam logic [24:0] DIV5_RECIP = 25'd13108;

    function automatic logic [CH_W-1:0] chan_filter(
        input window_t     w,
        input border_t     bd,
        input int unsigned sh,
        input logic        md
    );
        logic [13:0]        sum;
        logic [13:0]        wt;
        logic [CH_W-1:0]    v;
        logic               outside;
        logic [10:0]        q8;
        logic [24:0]        prod;
        logic [8:0]         blur_wide;
        logic [CH_W-1:0]    blur;
        logic [CH_W-1:0]    p;
        logic signed [11:0] s;
        logic [CH_W-1:0]    res;
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                outside = (r == 0 && bd.top) || (r == 2 && bd.bottom) ||
                          (c == 0 && bd.left) || (c == 2 && bd.right);
                // off-frame neighbours read as white
                v = outside ? '1 : w[r][c][sh +: CH_W];
                if (r == 1 && c == 1)
                begin
                    wt = 14'd20;
                end
                else if (r == 1 || c == 1)
                begin
                    wt = 14'd4;
                end
                else
                begin
                    wt = 14'd1;
                end
                sum = sum + 14'(v) * wt;
            end
        end
        // divide by 40 as shift by 3 then multiply by reciprocal of 5
        q8        = sum[13:3];
        prod      = 25'(q8) * DIV5_RECIP;
        blur_wide = prod[24:16];
        blur      = (blur_wide > 9'd255) ? '1 : blur_wide[CH_W-1:0];
        p         = w[1][1][sh +: CH_W];
        s         = $signed(12'(p) * 12'd3) - $signed(12'(blur) * 12'd2);
        if (s < 0)
        begin
            res = '0;
        end
        else if (s > 12'sd255)
        begin
            res = '1;
        end
        else
        begin
            res = s[CH_W-1:0];
        end
        return (md == MODE_SHARPEN) ? res : blur;
    endfunction

    assign red   = chan_filter(win, border, 0, mode);
    assign green = chan_filter(win, border, CH_W, mode);
    assign blue  = chan_filter(win, border, 2 * CH_W, mode);
    assign alpha = win[1][1][3*CH_W +: CH_W];

endmodule

// File: rtl/core/gauss_blur_sharpen_3x3.sv
// 3x3 gaussian blur / unsharp sharpen over an rgba raster stream. the block
// takes one item per clock and gives one result per clock when nothing
// stalls; a window's result passes the item, window and output registers,
// and results trail the input by one row plus one pixel, so after the
// last pixel of a frame send image_width + 1 flush items to drain it.
// weights are 1/4/20 over 40 per colour channel, off-frame neighbours count
// as white, alpha passes from the centre pixel. filter_mode picks blur (0)
// or 3*p - 2*blur (1). a write to image_width or image_height restarts the
// frame; write registers only while the block is idle. the two line buffers
// need no clearing after reset, so the block is ready at once.
module gauss_blur_sharpen_3x3 (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [gbs_pkg::CH_W-1:0]       in_red,
    input  logic [gbs_pkg::CH_W-1:0]       in_green,
    input  logic [gbs_pkg::CH_W-1:0]       in_blue,
    input  logic [gbs_pkg::CH_W-1:0]       in_alpha,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gbs_pkg::CH_W-1:0]       out_red,
    output logic [gbs_pkg::CH_W-1:0]       out_green,
    output logic [gbs_pkg::CH_W-1:0]       out_blue,
    output logic [gbs_pkg::CH_W-1:0]       out_alpha,
    output logic                           out_last
);
    import gbs_pkg::*;

    // configuration registers
    logic               filter_mode_reg;
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic               geo_write;

    // effective geometry
    logic [EW_W-1:0]    w_eff;
    logic [IMG_H_W-1:0] h_eff;

    // position counters, updated as items are accepted
    logic [COL_W-1:0]  in_col_reg;
    logic [COL_W-1:0]  in_col_next;
    logic [IROW_W-1:0] in_row_reg;
    logic [IROW_W-1:0] in_row_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;
    logic [OROW_W-1:0] out_row_reg;
    logic [OROW_W-1:0] out_row_next;
    logic [EW_W-1:0]   in_col_inc;
    logic [EW_W-1:0]   out_col_inc;

    // handshake and pipeline control
    logic        accept;
    logic        idle_flush;
    logic        take;
    stage_info_t cur_info;
    logic        s1_valid_reg;
    stage_info_t s1_info_reg;
    logic        s1_adv;
    logic        s2_valid_reg;
    stage_info_t s2_info_reg;
    logic        s2_adv;
    logic        s2_free;
    logic        s2_fire;
    logic        out_valid_reg;

    pixel_t   in_pixel;
    lb_ctrl_t lb_ctrl;
    window_t  win;

    // filter results and output register
    logic [CH_W-1:0] f_red;
    logic [CH_W-1:0] f_green;
    logic [CH_W-1:0] f_blue;
    logic [CH_W-1:0] f_alpha;
    logic [CH_W-1:0] out_red_reg;
    logic [CH_W-1:0] out_green_reg;
    logic [CH_W-1:0] out_blue_reg;
    logic [CH_W-1:0] out_alpha_reg;
    logic            out_last_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign geo_write = cfg_we &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= MODE_BLUR;
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:  filter_mode_reg  <= cfg_data[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero width or height acts as one, width saturates at the line length
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = EW_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = EW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = EW_W'(image_width_reg);
        end
    end

    assign h_eff = (image_height_reg == '0) ? IMG_H_W'(1) : image_height_reg;

    // ------------------------------------------------------------------
    // handshake: each stage moves when the one after it is free, so
    // bubbles close up and the input fills the free stages behind a held result
    // ------------------------------------------------------------------
    assign s2_adv   = !out_valid_reg || out_ready;
    assign s2_fire  = s2_valid_reg && s2_adv;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign accept   = in_valid && in_ready;

    // a flush before any item of the frame changes nothing
    assign idle_flush = (kind == KIND_FLUSH) && (in_col_reg == '0) && (in_row_reg == '0);
    assign take       = accept && !idle_flush;

    // flush items travel as an all-zero pixel
    assign in_pixel = (kind == KIND_FLUSH) ? '0 : {in_alpha, in_blue, in_green, in_red};

    // ------------------------------------------------------------------
    // position tracking, done at accept so the next item sees it at once
    // ------------------------------------------------------------------
    assign in_col_inc  = EW_W'(in_col_reg) + EW_W'(1);
    assign out_col_inc = EW_W'(out_col_reg) + EW_W'(1);

    always_comb
    begin
        // a result is due once a row plus one pixel has gone in
        cur_info.emit = (in_row_reg >= IROW_W'(2)) ||
                        (in_row_reg == IROW_W'(1) && in_col_reg != '0);
        cur_info.border.top    = (out_row_reg == '0);
        cur_info.border.bottom = (out_row_reg == h_eff - IMG_H_W'(1));
        cur_info.border.left   = (out_col_reg == '0);
        cur_info.border.right  = (out_col_inc >= w_eff);
        cur_info.last          = cur_info.emit && cur_info.border.bottom &&
                                 cur_info.border.right;

        if (in_col_inc >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = in_row_reg + IROW_W'(1);
        end
        else
        begin
            in_col_next = in_col_inc[COL_W-1:0];
            in_row_next = in_row_reg;
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cur_info.emit)
        begin
            if (out_col_inc >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + OROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_inc[COL_W-1:0];
            end
        end

        // frame end: everything starts over
        if (cur_info.last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (geo_write)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (take)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // stage valids: s1 holds the item while the line buffers are read,
    // s2 is the window holding a pixel whose result is due
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= s1_info_reg.emit;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_info_reg <= cur_info;
        end
        if (s1_adv)
        begin
            s2_info_reg <= s1_info_reg;
        end
    end

    // ------------------------------------------------------------------
    // line buffers and 3x3 window
    // ------------------------------------------------------------------
    assign lb_ctrl.accept = take;
    assign lb_ctrl.shift  = s1_adv;
    // window clears on a geometry write and after the frame's last result
    assign lb_ctrl.clear  = geo_write || (s2_fire && s2_info_reg.last);

    gbs_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lb_ctrl),
        .col   (in_col_reg),
        .pixel (in_pixel),
        .win   (win)
    );

    // ------------------------------------------------------------------
    // kernel and output register
    // ------------------------------------------------------------------
    gbs_filter u_filter (
        .win    (win),
        .border (s2_info_reg.border),
        .mode   (filter_mode_reg),
        .red    (f_red),
        .green  (f_green),
        .blue   (f_blue),
        .alpha  (f_alpha)
    );

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_red_reg   <= f_red;
            out_green_reg <= f_green;
            out_blue_reg  <= f_blue;
            out_alpha_reg <= f_alpha;
            out_last_reg  <= s2_info_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;
    assign out_last  = out_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // an empty output register means the whole pipe can take an item
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready
    ) else $error("input stalled with empty output register");

    // a held window item keeps its position info
    a_s2_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |=> s2_valid_reg && $stable(s2_info_reg)
    ) else $error("window stage lost or changed while stalled");

    // the frame's last item restarts every position counter
    a_frame_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        take && cur_info.last |=>
            in_col_reg == '0 && in_row_reg == '0 &&
            out_col_reg == '0 && out_row_reg == '0
    ) else $error("position counters not cleared after frame end");

    // output position stays inside the frame
    a_out_pos_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (EW_W'(out_col_reg) < w_eff) && (out_row_reg < h_eff)
    ) else $error("output position outside the frame");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import gbs_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 6;
    // a window's result passes the item, window and output registers in turn
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 200;
    localparam int MAX_REPORTS   = 10;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] red, green, blue, alpha;
    } src_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red, green, blue, alpha;
        logic            last;
    } rgba_result_t;

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    src_item_t             drive_item = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [CH_W-1:0]       out_red, out_green, out_blue, out_alpha;
    logic                  out_last;

    always #HALF_PERIOD clk = ~clk;

    gauss_blur_sharpen_3x3 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (drive_item.kind),
        .in_red    (drive_item.red),
        .in_green  (drive_item.green),
        .in_blue   (drive_item.blue),
        .in_alpha  (drive_item.alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .out_last  (out_last)
    );

    // ------------------------------------------------------------------
    // filter predictor: own copy of the line stores, window and counters
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]   lower_line [MAX_WIDTH];
    logic [PIX_W-1:0]   win [3][3];     // [top, mid, bottom][left, center, right]
    int unsigned        in_col, in_row, out_col, out_row;
    logic               mode_setting;
    logic [IMG_W_W-1:0] width_setting;
    logic [IMG_H_W-1:0] height_setting;

    rgba_result_t expected_pixels [$];
    src_item_t    pending_items [$];

    function automatic int unsigned frame_width();
        if (width_setting == 0)
            return 1;
        if (width_setting > MAX_WIDTH)
            return MAX_WIDTH;
        return width_setting;
    endfunction

    function automatic int unsigned frame_height();
        return (height_setting == 0) ? 1 : height_setting;
    endfunction

    function void restart_frame();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function void reset_predictor();
        mode_setting   = MODE_BLUR;
        width_setting  = IMAGE_WIDTH_RESET;
        height_setting = IMAGE_HEIGHT_RESET;
        // never-written entries only feed off-frame taps, any value will do
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        restart_frame();
    endfunction

    function void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FILTER_MODE:
                mode_setting = val[0];
            REG_IMAGE_WIDTH:
            begin
                width_setting = val[IMG_W_W-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_setting = val[IMG_H_W-1:0];
                restart_frame();
            end
            default:
                ;
        endcase
    endfunction

    // advance the window by one accepted item, queue the result it causes
    function void filter_item(input src_item_t it);
        int unsigned      w, h, sum, blur;
        int               nr, nc, wt, v, s;
        logic [PIX_W-1:0] pix, up, lo, center;
        logic             emit;
        logic [CH_W-1:0]  chans [3];
        rgba_result_t     res;

        w = frame_width();
        h = frame_height();
        // flush with nothing of the frame received yet is dropped
        if (it.kind == KIND_FLUSH && in_col == 0 && in_row == 0)
            return;
        // a flush travels like an all-zero pixel
        pix = (it.kind == KIND_FLUSH) ? '0 : {it.alpha, it.blue, it.green, it.red};

        up = upper_line[in_col];
        lo = lower_line[in_col];
        upper_line[in_col] = lo;
        lower_line[in_col] = pix;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = pix;

        // output trails the input by one row plus one pixel
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (!emit)
            return;

        center = win[1][1];
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    nr = int'(out_row) + r - 1;
                    nc = int'(out_col) + c - 1;
                    wt = (r == 1 && c == 1) ? 20 : ((r == 1 || c == 1) ? 4 : 1);
                    // off-frame neighbors read as white
                    v = 255;
                    if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w))
                        v = win[r][c][ch*CH_W +: CH_W];
                    sum += v * wt;
                end
            end
            blur = sum / 40;
            if (blur > 255)
                blur = 255;
            if (mode_setting == MODE_SHARPEN)
            begin
                s = 3 * int'(center[ch*CH_W +: CH_W]) - 2 * int'(blur);
                if (s < 0)
                    s = 0;
                if (s > 255)
                    s = 255;
                chans[ch] = s[CH_W-1:0];
            end
            else
            begin
                chans[ch] = blur[CH_W-1:0];
            end
        end

        res.red   = chans[0];
        res.green = chans[1];
        res.blue  = chans[2];
        res.alpha = center[3*CH_W +: CH_W];
        res.last  = (out_row == h - 1) && (out_col == w - 1);
        expected_pixels.push_back(res);

        // the last pixel of a frame starts the next one from scratch
        if (res.last)
        begin
            restart_frame();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row = (out_row + 1) & 32'hFFFF;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: presents pending items at the falling edge
    // ------------------------------------------------------------------
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   items_queued = 0;
    int   items_taken  = 0;
    logic item_taken   = 1'b0;

    // handshake sampling, the predictor follows every accepted item
    always @(posedge clk)
    begin
        item_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            filter_item(drive_item);
            items_taken++;
        end
    end

    // valid stays up with a stable item until it is taken
    always @(negedge clk)
    begin
        if (!in_valid || item_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                drive_item <= pending_items.pop_front();
                in_valid   <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    logic hold_request = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    always @(negedge clk)
    begin
        // a new request starts the hold-off count
        if (hold_request && !hold_seen)
            hold_left = HOLD_CYCLES;
        hold_seen = hold_request;
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // every result item is checked against the oldest expected pixel
    int           mismatch_count = 0;
    rgba_result_t seen_pixel, want_pixel;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_pixel = '{out_red, out_green, out_blue, out_alpha, out_last};
            if (expected_pixels.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result item: r %0d g %0d b %0d a %0d last %0d",
                             seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                             seen_pixel.alpha, seen_pixel.last);
                mismatch_count++;
            end
            else
            begin
                want_pixel = expected_pixels.pop_front();
                if (seen_pixel.red !== want_pixel.red ||
                    seen_pixel.green !== want_pixel.green ||
                    seen_pixel.blue !== want_pixel.blue ||
                    seen_pixel.alpha !== want_pixel.alpha ||
                    seen_pixel.last !== want_pixel.last)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected r %0d g %0d b %0d a %0d last %0d, %s",
                                 want_pixel.red, want_pixel.green, want_pixel.blue,
                                 want_pixel.alpha, want_pixel.last,
                                 $sformatf("got r %0d g %0d b %0d a %0d last %0d",
                                           seen_pixel.red, seen_pixel.green,
                                           seen_pixel.blue, seen_pixel.alpha,
                                           seen_pixel.last));
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles where no item moves on either side
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_setting(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all items taken, all results seen, then let the pipeline settle
    task automatic wait_idle();
        while (items_taken != items_queued || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_item(input logic k, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input logic [CH_W-1:0] a);
        pending_items.push_back('{k, r, g, b, a});
        items_queued++;
    endtask

    // channel values lean toward the extremes to hit the clamps
    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel();
        push_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic push_flush();
        push_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    // one frame plus its drain, optionally cut short
    task automatic queue_frame(input int unsigned w, input int unsigned h, input bit broken);
        int unsigned total, cut;
        total = w * h + w + 1;
        cut   = broken ? $urandom_range(1, total - 1) : total;
        // stray flush ahead of the frame, dropped by the block
        if ($urandom_range(0, 4) == 0)
            push_flush();
        for (int unsigned k = 0; k < cut; k++)
        begin
            if (k < w * h)
            begin
                // early flush is a black pixel unless it is the frame's first item
                if ($urandom_range(0, 19) == 0)
                    push_flush();
                else
                    push_pixel();
            end
            else
            begin
                // pixels may stand in for drain flushes
                if ($urandom_range(0, 3) == 0)
                    push_pixel();
                else
                    push_flush();
            end
        end
    endtask

    // new mode and geometry; geometry writes always restart the frame
    task automatic configure_random();
        int unsigned           w_raw, h_raw;
        logic [CFG_DATA_W-1:0] d;
        wait_idle();
        write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        case ($urandom_range(0, 9))
            0: w_raw = 0;
            1: w_raw = $urandom_range(9, 40);
            default: w_raw = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
            0: h_raw = 0;
            1: h_raw = $urandom_range(5, 8);
            default: h_raw = $urandom_range(1, 4);
        endcase
        // upper data bits beyond the width field must be ignored
        d = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        d[IMG_W_W-1:0] = IMG_W_W'(w_raw);
        write_reg(REG_IMAGE_WIDTH, d);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        int unsigned phase_start, nframes;

        reset_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: 3x2 blur frame with extreme pixels
        write_reg(REG_FILTER_MODE, MODE_BLUR);
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 2);
        push_item(KIND_FLUSH, '1, '1, '1, '1);
        push_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
        push_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
        push_item(KIND_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255);
        push_item(KIND_PIXEL, 8'd255, 8'd0, 8'd255, 8'd0);
        push_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
        push_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
        push_item(KIND_FLUSH, '1, '1, '1, '1);
        repeat (3) push_item(KIND_FLUSH, '0, '0, '0, '0);

        // directed: 2x2 sharpen with an early flush and an extra pixel in the drain
        wait_idle();
        write_reg(REG_FILTER_MODE, MODE_SHARPEN);
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_UNUSED, '1);
        push_item(KIND_PIXEL, 8'd255, 8'd0, 8'd255, 8'd0);
        push_item(KIND_FLUSH, '1, '1, '1, '1);
        push_item(KIND_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255);
        push_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
        push_item(KIND_FLUSH, '0, '0, '0, '0);
        push_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
        push_item(KIND_FLUSH, '0, '0, '0, '0);

        // directed: zero width and height both act as 1, single-pixel frame
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        push_pixel();
        push_flush();
        push_flush();

        // random frames over four handshake regimes
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 59;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 59;
                end
                default:
                begin
                    tx_idle_pct  = 32;
                    rx_stall_pct = 32;
                end
            endcase
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
            begin
                configure_random();
                nframes = $urandom_range(1, 3);
                for (int f = 0; f < nframes; f++)
                    queue_frame(frame_width(), frame_height(),
                                (f == nframes - 1) && ($urandom_range(0, 4) == 0));
            end

            if (phase == 0)
            begin
                // receiver holds off while a full frame is offered, input must stall
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, 8);
                write_reg(REG_IMAGE_HEIGHT, 6);
                hold_request = 1'b1;
                queue_frame(8, 6, 1'b0);

                // tallest frame on a one-pixel column, partial
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, 1);
                write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
                repeat (40) push_pixel();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
